/* sv/mmwf_pkg.sv */
// Shared constants and types for the median and mean window filter.
`default_nettype none

package mmwf_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int SAMPLE_W    = 16;
    localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
    localparam int MEDIAN_RANK = (WINDOW_SIZE - 1) / 2;
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int DIV_SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
    localparam int MULT_W      = SUM_W + 2;
    localparam int PROD_W      = SUM_W + MULT_W;

    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);

    typedef logic [SAMPLE_W-1:0]       t_sample;
    typedef t_sample [WINDOW_SIZE-1:0] t_window;
    typedef logic [SUM_W-1:0]          t_sum;

endpackage

`default_nettype wire

/* sv/mmwf_median.sv */
// Rank-count median selector over the whole window.
`default_nettype none

module mmwf_median (
    input  mmwf_pkg::t_window i_window,
    output mmwf_pkg::t_sample o_median
);
    import mmwf_pkg::*;

    logic [CNT_W-1:0] below [WINDOW_SIZE];
    logic [CNT_W-1:0] same  [WINDOW_SIZE];
    logic [CNT_W:0]   upper [WINDOW_SIZE];
    logic             hit   [WINDOW_SIZE];

    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            below[i] = '0;
            same[i]  = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (i_window[j] < i_window[i]) begin
                    below[i] = below[i] + CNT_W'(1);
                end else if (i_window[j] == i_window[i]) begin
                    same[i] = same[i] + CNT_W'(1);
                end
            end
            upper[i] = {1'b0, below[i]} + {1'b0, same[i]};
            hit[i]   = ({1'b0, below[i]} <= (CNT_W+1)'(MEDIAN_RANK))
                    && ((CNT_W+1)'(MEDIAN_RANK) < upper[i]);
        end
    end

    // first matching entry wins
    always_comb begin
        o_median = '0;
        for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_median = i_window[i];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/median_and_mean_window_filter_top.sv */
// Top level of the median and mean window filter.
`default_nettype none

// Each accepted sample overwrites the oldest entry of a WINDOW_SIZE-entry ring
// window (entries never written read as zero); the block returns the median
// (lower middle for an even size) and the truncated mean of the window after
// insertion. One item is accepted every cycle unless o_stall is high; the item
// lands in the window register at the accepting edge, then a stage ranks the
// entries and sums them, and a stage divides the sum by a constant reciprocal
// multiply before the result is presented. o_stall rises only while all three
// stages are full and the output is stalled.

module median_and_mean_window_filter_top (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  mmwf_pkg::t_sample i_sample,
    output logic              o_valid,
    input  wire               i_stall,
    output mmwf_pkg::t_sample o_median,
    output mmwf_pkg::t_sample o_mean
);
    import mmwf_pkg::*;

    t_window            r_window;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  n_slot;
    logic               r_pend;
    logic               r_calc_vld;
    t_sample            r_calc_median;
    t_sum               r_calc_sum;
    logic               r_out_vld;
    t_sample            r_out_median;
    t_sample            r_out_mean;

    t_sample            n_median;
    t_sum               n_sum;
    logic [PROD_W-1:0]  prod;
    logic               out_rdy;
    logic               calc_rdy;
    logic               accept;

    assign out_rdy  = !r_out_vld || !i_stall;
    assign calc_rdy = !r_calc_vld || out_rdy;
    assign o_stall  = r_pend && !calc_rdy;
    assign accept   = i_valid && !o_stall;
    assign n_slot   = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);

    mmwf_median u_median (
        .i_window (r_window),
        .o_median (n_median)
    );

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            n_sum = n_sum + SUM_W'(r_window[i]);
        end
    end

    assign prod = PROD_W'(r_calc_sum) * PROD_W'(DIV_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_slot   <= '0;
        end else if (accept) begin
            r_window[r_slot] <= i_sample;
            r_slot           <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_calc_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= 1'b1;
            end else if (calc_rdy) begin
                r_pend <= 1'b0;
            end
            if (calc_rdy) begin
                r_calc_vld <= r_pend;
            end
            if (out_rdy) begin
                r_out_vld <= r_calc_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_rdy && r_pend) begin
            r_calc_median <= n_median;
            r_calc_sum    <= n_sum;
        end
        if (out_rdy && r_calc_vld) begin
            r_out_median <= r_calc_median;
            r_out_mean   <= prod[DIV_SHIFT +: SAMPLE_W];
        end
    end

    assign o_valid  = r_out_vld;
    assign o_median = r_out_median;
    assign o_mean   = r_out_mean;

endmodule

`default_nettype wire

/* sv/mmwf_checker.sv */
// Port-level assertions for the median and mean window filter, bound to the top level.
`default_nettype none

module mmwf_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_stall,
    input wire               o_valid,
    input wire               i_stall,
    input mmwf_pkg::t_sample o_median,
    input mmwf_pkg::t_sample o_mean
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_median) && $stable(o_mean))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while output moves");

endmodule

bind median_and_mean_window_filter_top mmwf_checker u_mmwf_checker (.*);

`default_nettype wire

/* tb/sv/median_and_mean_window_filter_top_tb.sv */
// Testbench for the median and mean window filter: queue-fed driver, checking monitor.
module median_and_mean_window_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmwf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LATENCY     = 3;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AT     = 700;

    typedef struct packed {
        t_sample median;
        t_sample mean;
    } t_stats;

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    i_valid  = 1'b0;
    logic    i_stall  = 1'b0;
    t_sample i_sample = '0;
    logic    o_stall;
    logic    o_valid;
    t_sample o_median;
    t_sample o_mean;

    t_sample     sample_q[$];
    t_stats      stats_q[$];
    t_sample     win[WINDOW_SIZE];
    int unsigned wr_slot = 0;

    bit          tx_busy = 1'b0;
    bit          rx_busy = 1'b0;
    bit          sample_taken = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    int unsigned cycles = 0;
    int unsigned n_in = 0;
    int unsigned n_out = 0;
    int unsigned n_held = 0;
    int unsigned errors = 0;
    t_stats      want;

    t_sample corner_set[24] = '{
        16'hFFFF, 16'h0001, 16'h0002, 16'h0003,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000,
        16'h0064, 16'h0064, 16'h0064, 16'h0007, 16'h2328,
        16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF,
        16'h0040, 16'hFFFE, 16'h0001, 16'h0001
    };

    median_and_mean_window_filter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_median (o_median),
        .o_mean   (o_mean)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_stats window_stats();
        t_stats           s;
        int unsigned      below;
        int unsigned      same;
        logic [SUM_W+3:0] total;
        s     = '0;
        total = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            total += win[i];
        end
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            below = 0;
            same  = 0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (win[j] < win[i]) begin
                    below++;
                end else if (win[j] == win[i]) begin
                    same++;
                end
            end
            if (below <= MEDIAN_RANK && MEDIAN_RANK < below + same) begin
                s.median = win[i];
            end
        end
        s.mean = t_sample'(total / WINDOW_SIZE);
        return s;
    endfunction

    function automatic void take_sample(t_sample s);
        win[wr_slot] = s;
        wr_slot      = (wr_slot == WINDOW_SIZE - 1) ? 0 : wr_slot + 1;
        stats_q.push_back(window_stats());
    endfunction

    function automatic int unsigned idle_len(bit busy);
        int unsigned r;
        if (!busy) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic report_mismatch(string what, t_sample got, t_sample exp_val);
        errors++;
        if (errors <= 50) begin
            $display("mismatch at result %0d: %s got %h, expected %h",
                     n_out, what, got, exp_val);
        end
    endtask

    // drive samples from the queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || sample_taken) begin
            if (tx_gap != 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                i_sample <= sample_q.pop_front();
                i_valid  <= 1'b1;
                tx_gap = idle_len(tx_busy);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            rx_gap = idle_len(rx_busy);
        end
    end

    // hold the output off once, long enough to back up the pipeline
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** median_and_mean_window_filter_top: FAILED **");
            $finish;
        end else begin
            if (i_rst_n) begin
                if (i_valid && !o_stall) begin
                    take_sample(i_sample);
                    n_in <= n_in + 1;
                end
                if (i_valid && o_stall) begin
                    n_held++;
                end
                if (o_valid && !i_stall) begin
                    if (stats_q.size() == 0) begin
                        report_mismatch("unexpected result, median", o_median, '0);
                    end else begin
                        want = stats_q.pop_front();
                        if (o_median !== want.median) begin
                            report_mismatch("median", o_median, want.median);
                        end
                        if (o_mean !== want.mean) begin
                            report_mismatch("mean", o_mean, want.mean);
                        end
                    end
                    n_out++;
                end
            end
            sample_taken = i_valid && !o_stall;
        end
    end

    task automatic run_phase(bit tx_mode, bit rx_mode, int unsigned count, bit corners);
        t_sample s;
        int      walk;
        @(posedge i_clk);
        tx_busy = tx_mode;
        rx_busy = rx_mode;
        walk    = int'($urandom_range(65535));
        if (corners) begin
            foreach (corner_set[k]) begin
                sample_q.push_back(corner_set[k]);
            end
        end
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1, 2: s = t_sample'($urandom);
                3, 4:    s = t_sample'($urandom_range(15));
                5:       s = 16'hFFFF - t_sample'($urandom_range(15));
                default: begin
                    walk = walk + int'($urandom_range(512)) - 256;
                    if (walk < 0) walk = 0;
                    if (walk > 65535) walk = 65535;
                    s = t_sample'(walk);
                end
            endcase
            sample_q.push_back(s);
        end
        while (sample_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            win[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(1'b0, 1'b0, 0, 1'b1);
        run_phase(1'b1, 1'b0, 500, 1'b0);
        run_phase(1'b0, 1'b1, 500, 1'b0);
        run_phase(1'b1, 1'b1, 500, 1'b0);
        run_phase(1'b0, 1'b0, 375, 1'b0);

        while (i_valid || stats_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY * 4) @(negedge i_clk);
        if (stats_q.size() != 0) begin
            report_mismatch("missing result, median", '0, stats_q[0].median);
        end

        $display("covered %0d samples and %0d results, corner values and random data",
                 n_in, n_out);
        $display("input held off for %0d cycles under random and long output stalls",
                 n_held);
        if (errors == 0) begin
            $display("** median_and_mean_window_filter_top: PASSED **");
        end else begin
            $display("** median_and_mean_window_filter_top: FAILED **");
        end
        $finish;
    end

endmodule
